### rtl/core/bgr420_pkg.sv
// Shared types and constants for the BGRA to I420 converter core.
`timescale 1ns / 1ps

package bgr420_pkg;

   // Configuration register file
   localparam int CSR_DATA_W = 13;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // Luma coefficients
   localparam logic [7:0] COEF_Y_R    = 8'd66;
   localparam logic [7:0] COEF_Y_G    = 8'd129;
   localparam logic [7:0] COEF_Y_B    = 8'd25;
   localparam logic [7:0] LUMA_ROUND  = 8'd128;
   localparam logic [7:0] LUMA_OFFSET = 8'd16;

   // Chroma coefficients (magnitudes; signs applied in the datapath)
   localparam logic [7:0] COEF_CB_R = 8'd38;
   localparam logic [7:0] COEF_CB_G = 8'd74;
   localparam logic [7:0] COEF_CB_B = 8'd112;
   localparam logic [7:0] COEF_CR_R = 8'd112;
   localparam logic [7:0] COEF_CR_G = 8'd94;
   localparam logic [7:0] COEF_CR_B = 8'd18;
   // Rounding term plus the 128 offset folded in above the binary point
   localparam logic [15:0] CHROMA_BIAS = 16'd32896;

   // Input pixel
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       frame_end;
   } rsp_type;

   // Horizontal pair sums of one column pair
   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } pair_sum_type;

   // Per-pixel decisions from the scan logic
   typedef struct packed {
      logic chroma_valid;
      logic use_line;
      logic frame_end;
   } block_ctl_type;

endpackage

### rtl/core/bgra_to_i420_converter_core.sv
// Top level of the BGRA to I420 converter: handshake, pipeline registers, line buffer.
//
//   channel | direction | transfer condition         | payload
//   --------+-----------+----------------------------+----------------------------------
//   req     | in        | req_valid && req_ready     | req_data  (blue, green, red)
//   rsp     | out       | rsp_valid && rsp_ready     | rsp_data  (luma, chroma, frame_end)
//   csr     | in        | csr_we                     | csr_index, csr_wdata
//
// One pixel per clock while rsp is not stalled; each pixel passes the first stage and
// then the output register before rsp_valid rises. The line buffer is read and written
// at the req transfer edge, its read data registered alongside the pixel; the color math
// sits between that stage and the output register. A stalled rsp holds the output
// register; a pixel still enters while the first stage is empty. Reset is synchronous
// and needs no clearing pass: line buffer data is only used where the row above wrote it.
`timescale 1ns / 1ps

module bgra_to_i420_converter_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bgr420_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bgr420_pkg::rsp_type                 rsp_data,
   input  logic                                csr_we,
   input  bgr420_pkg::csr_index_type           csr_index,
   input  logic [bgr420_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bgr420_pkg::*;

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic              accept, advance;
   pair_sum_type      pair, line_rd;
   block_ctl_type     ctl;
   logic              line_wr;
   logic [LINE_AW-1:0] line_addr;
   rsp_type           result;

   logic              s1_vld_ff, s1_vld_in;
   req_type           s1_pix_ff;
   pair_sum_type      s1_pair_ff;
   block_ctl_type     s1_ctl_ff;
   logic              rsp_vld_ff;
   rsp_type           rsp_data_ff;

   // Handshake
   assign advance   = !rsp_vld_ff || rsp_ready;
   assign req_ready = advance || !s1_vld_ff;
   assign accept    = req_valid && req_ready;

   bgr420_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (LINE_AW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .pixel     (req_data),
      .pair      (pair),
      .ctl       (ctl),
      .line_wr   (line_wr),
      .line_addr (line_addr)
   );

   bgr420_line_buf #(
      .DEPTH (LINE_DEPTH),
      .AW    (LINE_AW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept && line_wr),
      .wr_addr (line_addr),
      .wr_data (pair),
      .rd_en   (accept),
      .rd_addr (line_addr),
      .rd_data (line_rd)
   );

   // First stage: fill on transfer, drain when the output moves
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_data;
         s1_pair_ff <= pair;
         s1_ctl_ff  <= ctl;
      end
   end

   bgr420_color u_color (
      .pixel    (s1_pix_ff),
      .pair     (s1_pair_ff),
      .line_sum (line_rd),
      .ctl      (s1_ctl_ff),
      .result   (result)
   );

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // The last pixel of a frame always closes a chroma block
   a_frame_end_chroma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.chroma_valid)
      else $error("frame end without chroma block");

   // Chroma fields are zero outside a closed block
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.chroma_valid |-> rsp_data.cb == 8'd0 && rsp_data.cr == 8'd0)
      else $error("chroma present without block");

   // Luma stays in studio range
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.luma >= 8'd16 && rsp_data.luma <= 8'd235)
      else $error("luma out of range");

   // An empty first stage always takes a pixel
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> req_ready)
      else $error("ready low with empty first stage");

endmodule

### rtl/core/bgr420_line_buf.sv
// Line buffer holding the pair sums of the last even row.
`timescale 1ns / 1ps

module bgr420_line_buf #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  bgr420_pkg::pair_sum_type   wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output bgr420_pkg::pair_sum_type   rd_data
);
   import bgr420_pkg::*;

   pair_sum_type mem [DEPTH];
   pair_sum_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bgr420_scan.sv
// Raster position tracking, configuration registers and pair-sum formation.
`timescale 1ns / 1ps

module bgr420_scan #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int AW         = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  bgr420_pkg::csr_index_type           csr_index,
   input  logic [bgr420_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                                accept,
   input  bgr420_pkg::req_type                 pixel,
   output bgr420_pkg::pair_sum_type            pair,
   output bgr420_pkg::block_ctl_type           ctl,
   output logic                                line_wr,
   output logic [AW-1:0]                       line_addr
);
   import bgr420_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   req_type               left_ff;
   logic [WW-1:0]         width_eff;
   logic [HW-1:0]         height_eff;
   logic                  col_last, row_last, hold_left, even_row;

   // Clamp the frame size into 1..MAX
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(height_ff);
      end
   end

   // Position decisions
   assign col_last  = (WW'(col_ff) == width_eff - WW'(1));
   assign row_last  = (HW'(row_ff) == height_eff - HW'(1));
   assign even_row  = !row_ff[0];
   assign hold_left = !col_ff[0] && !col_last;

   // Pair sums: left partner plus this pixel, or this pixel twice on a lone last column
   always_comb begin
      if (col_ff[0]) begin
         pair.blue  = {1'b0, left_ff.blue}  + {1'b0, pixel.blue};
         pair.green = {1'b0, left_ff.green} + {1'b0, pixel.green};
         pair.red   = {1'b0, left_ff.red}   + {1'b0, pixel.red};
      end else begin
         pair.blue  = {pixel.blue, 1'b0};
         pair.green = {pixel.green, 1'b0};
         pair.red   = {pixel.red, 1'b0};
      end
   end

   assign line_wr          = !hold_left && even_row && !row_last;
   assign line_addr        = AW'(col_ff >> 1);
   assign ctl.chroma_valid = !hold_left && !(even_row && !row_last);
   assign ctl.use_line     = row_ff[0];
   assign ctl.frame_end    = col_last && row_last;

   // Advance the raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   // Register writes restart the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (hold_left) begin
            left_ff <= pixel;
         end
      end
   end

endmodule

### rtl/core/bgr420_color.sv
// Color conversion datapath: luma per pixel, chroma from the 2x2 block average.
`timescale 1ns / 1ps

module bgr420_color (
   input  bgr420_pkg::req_type        pixel,
   input  bgr420_pkg::pair_sum_type   pair,
   input  bgr420_pkg::pair_sum_type   line_sum,
   input  bgr420_pkg::block_ctl_type  ctl,
   output bgr420_pkg::rsp_type        result
);
   import bgr420_pkg::*;

   logic [9:0]  sum_b, sum_g, sum_r;
   logic [7:0]  avg_b, avg_g, avg_r;
   logic [15:0] y_acc;
   logic [16:0] cb_acc, cr_acc;

   // Luma
   assign y_acc = 16'(COEF_Y_R) * 16'(pixel.red) + 16'(COEF_Y_G) * 16'(pixel.green)
                + 16'(COEF_Y_B) * 16'(pixel.blue) + 16'(LUMA_ROUND);

   // Block sum: stored row pair plus this pair, or this pair twice on a lone last row
   always_comb begin
      if (ctl.use_line) begin
         sum_b = {1'b0, line_sum.blue}  + {1'b0, pair.blue};
         sum_g = {1'b0, line_sum.green} + {1'b0, pair.green};
         sum_r = {1'b0, line_sum.red}   + {1'b0, pair.red};
      end else begin
         sum_b = {pair.blue, 1'b0};
         sum_g = {pair.green, 1'b0};
         sum_r = {pair.red, 1'b0};
      end
   end

   assign avg_b = sum_b[9:2];
   assign avg_g = sum_g[9:2];
   assign avg_r = sum_r[9:2];

   // Chroma; the bias keeps both sums positive
   assign cb_acc = 17'(COEF_CB_B) * 17'(avg_b) + 17'(CHROMA_BIAS)
                 - 17'(COEF_CB_R) * 17'(avg_r) - 17'(COEF_CB_G) * 17'(avg_g);
   assign cr_acc = 17'(COEF_CR_R) * 17'(avg_r) + 17'(CHROMA_BIAS)
                 - 17'(COEF_CR_G) * 17'(avg_g) - 17'(COEF_CR_B) * 17'(avg_b);

   assign result.luma         = y_acc[15:8] + LUMA_OFFSET;
   assign result.chroma_valid = ctl.chroma_valid;
   assign result.cb           = ctl.chroma_valid ? cb_acc[15:8] : 8'd0;
   assign result.cr           = ctl.chroma_valid ? cr_acc[15:8] : 8'd0;
   assign result.frame_end    = ctl.frame_end;

endmodule

### tb/bgra_to_i420_converter_core_tb.sv
// Self-checking testbench for the BGRA to I420 converter core, with a pixel predictor.
`timescale 1ns / 1ps

module bgra_to_i420_converter_core_tb;
   import bgr420_pkg::*;

   localparam int MAX_DIM      = 4096;
   localparam int LINE_SLOTS   = 2048;
   localparam int RANDOM_ITEMS = 780;
   localparam int QUIET_AFTER  = 680;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Pixels waiting to be sent and converted results waiting to arrive
   req_type pixel_queue[$];
   rsp_type expected_yuv[$];

   int  mismatch_count = 0;
   int  send_gap = 0;
   int  ready_hold = 0;
   bit  steady_tail = 1'b0;

   // Predictor state: registers, scan position, held left pixel, line of pair sums
   logic [CSR_DATA_W-1:0] cfg_width;
   logic [CSR_DATA_W-1:0] cfg_height;
   int                    col_pos;
   int                    row_pos;
   req_type               held_left;
   pair_sum_type          line_sums[LINE_SLOTS];

   bgra_to_i420_converter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Zero acts as one, anything past the maximum acts as the maximum
   function automatic int clamp_dim(logic [CSR_DATA_W-1:0] value);
      if (value == 0) return 1;
      if (int'(value) > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   // Convert one pixel and advance the scan position
   function automatic rsp_type convert_pixel(req_type px);
      int w, h, c, r, slot, y, u, v;
      int pb, pg, pr, sb, sg, sr, ab, ag, ar;
      rsp_type res;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      res = '0;
      y = ((66 * int'(px.red) + 129 * int'(px.green) + 25 * int'(px.blue) + 128) >> 8) + 16;
      res.luma = 8'(y);
      if (c % 2 == 0 && c + 1 < w) begin
         held_left = px;
      end else begin
         slot = (c >> 1) % LINE_SLOTS;
         if (c % 2 == 1) begin
            pb = int'(held_left.blue) + int'(px.blue);
            pg = int'(held_left.green) + int'(px.green);
            pr = int'(held_left.red) + int'(px.red);
         end else begin
            // odd width: last column pairs with itself
            pb = 2 * int'(px.blue);
            pg = 2 * int'(px.green);
            pr = 2 * int'(px.red);
         end
         if (r % 2 == 0 && r + 1 < h) begin
            line_sums[slot].blue  = 9'(pb);
            line_sums[slot].green = 9'(pg);
            line_sums[slot].red   = 9'(pr);
         end else begin
            if (r % 2 == 1) begin
               sb = int'(line_sums[slot].blue) + pb;
               sg = int'(line_sums[slot].green) + pg;
               sr = int'(line_sums[slot].red) + pr;
            end else begin
               // odd height: last row pairs with itself
               sb = 2 * pb;
               sg = 2 * pg;
               sr = 2 * pr;
            end
            ab = sb >> 2;
            ag = sg >> 2;
            ar = sr >> 2;
            u = 112 * ab - 38 * ar - 74 * ag + 128 + 32768;
            v = 112 * ar - 94 * ag - 18 * ab + 128 + 32768;
            res.cb = 8'(u >> 8);
            res.cr = 8'(v >> 8);
            res.chroma_valid = 1'b1;
         end
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         if (r + 1 >= h) begin
            row_pos = 0;
            res.frame_end = 1'b1;
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      return res;
   endfunction

   function automatic req_type make_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      req_type px;
      px.blue  = b;
      px.green = g;
      px.red   = r;
      return px;
   endfunction

   // Append one pixel to the send queue
   task automatic queue_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      pixel_queue.insert(pixel_queue.size(), make_pixel(b, g, r));
   endtask

   // Lean toward the channel extremes now and then
   function automatic logic [7:0] random_channel();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_random_pixels(int count);
      for (int i = 0; i < count; i++) begin
         queue_pixel(random_channel(), random_channel(), random_channel());
      end
   endtask

   // Block until every pixel is sent and every result has come back
   task automatic wait_drained();
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || expected_yuv.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Write one register while idle; any write restarts the frame
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) begin
         cfg_width = value;
      end else begin
         cfg_height = value;
      end
      col_pos = 0;
      row_pos = 0;
      @(negedge clock);
   endtask

   task automatic report_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Drive pixels; predict each one at its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_yuv.insert(expected_yuv.size(), convert_pixel(req_data));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               req_data  <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               if (!steady_tail && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result transfer against the oldest prediction; stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_yuv.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            end else begin
               rsp_type want;
               want = expected_yuv.pop_front();
               report_field("luma", want.luma, rsp_data.luma);
               report_field("chroma_valid", want.chroma_valid, rsp_data.chroma_valid);
               report_field("cb", want.cb, rsp_data.cb);
               report_field("cr", want.cr, rsp_data.cr);
               report_field("frame_end", want.frame_end, rsp_data.frame_end);
            end
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int random_sent;
      int w, h, frame_px, count;
      int pick;
      logic [CSR_DATA_W-1:0] dim;

      cfg_width  = FRAME_WIDTH_RST;
      cfg_height = FRAME_HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      held_left  = '0;
      foreach (line_sums[i]) line_sums[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: luma extremes and primaries, no chroma on the first row
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'd255, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd255, 8'd0);
      queue_pixel(8'd0, 8'd255, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd255);
      wait_drained();

      // Zero size acts as a 1x1 frame: every pixel closes a block and the frame
      write_csr(CSR_FRAME_WIDTH, '0);
      write_csr(CSR_FRAME_HEIGHT, '0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd0);
      wait_drained();

      // Odd width and height: last column and last row count twice
      write_csr(CSR_FRAME_WIDTH, 13'd3);
      write_csr(CSR_FRAME_HEIGHT, 13'd3);
      queue_pixel(8'd255, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'd255, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'd255, 8'd255, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd255, 8'd255);
      wait_drained();

      // Random geometries, whole frames mostly, some cut short by the next write
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         steady_tail = (random_sent >= QUIET_AFTER);
         pick = $urandom_range(0, 4);
         if (random_sent == 0 || pick != 0) begin
            pick = $urandom_range(0, 9);
            dim = (pick < 7) ? 13'($urandom_range(1, 8)) :
                  (pick < 9) ? 13'($urandom_range(9, 40)) : 13'd0;
            write_csr(CSR_FRAME_WIDTH, dim);
         end
         if (random_sent == 0 || pick != 1) begin
            pick = $urandom_range(0, 9);
            dim = (pick < 8) ? 13'($urandom_range(1, 6)) : 13'($urandom_range(0, 12));
            write_csr(CSR_FRAME_HEIGHT, dim);
         end
         w = clamp_dim(cfg_width);
         h = clamp_dim(cfg_height);
         frame_px = w * h;
         count = frame_px * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame_px);
         if (count > 200) count = 200;
         if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
         queue_random_pixels(count);
         random_sent += count;
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
